>>> hw/rtl/ptt_pkg.sv
`default_nettype none

package ptt_pkg;

  localparam int DEF_PROCESS_COUNT = 4;
  localparam int PAGES_PER_PROCESS = 16;

  localparam int ENTRY_W  = 16;
  localparam int VADDR_W  = 12;
  localparam int PID_W    = 4;
  localparam int MASK_W   = 3;
  localparam int OFFSET_W = 8;

  // Entry layout
  localparam int PRESENT_POS  = 15;
  localparam int ACCESSED_POS = 14;
  localparam int MODIFIED_POS = 13;
  localparam int WRITE_BIT    = 1;

  localparam logic [ENTRY_W-1:0] PERM_BITS   = 16'h0007;
  localparam logic [ENTRY_W-1:0] FRAME_BITS  = 16'h0F00;
  localparam logic [ENTRY_W-1:0] OFFSET_BITS = 16'h00FF;

  typedef logic [1:0] req_type_t;
  localparam req_type_t REQ_TRANSLATE = 2'd0;
  localparam req_type_t REQ_WRITE     = 2'd1;
  localparam req_type_t REQ_READ      = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK          = 2'd0;
  localparam status_t ST_BAD_PROCESS = 2'd1;
  localparam status_t ST_NOT_PRESENT = 2'd2;
  localparam status_t ST_DENIED      = 2'd3;

  typedef logic [ENTRY_W-1:0] entry_t;

endpackage

`default_nettype wire

>>> hw/rtl/ptt_store.sv
`default_nettype none

module ptt_store #(
  parameter int DEPTH  = ptt_pkg::DEF_PROCESS_COUNT * ptt_pkg::PAGES_PER_PROCESS,
  parameter int SLOT_W = $clog2(DEPTH)
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  rd_en,
  input  wire [SLOT_W-1:0]     rd_slot,
  output ptt_pkg::entry_t      rd_entry,
  input  wire                  wr_en,
  input  wire [SLOT_W-1:0]     wr_slot,
  input  wire ptt_pkg::entry_t wr_data
);

  ptt_pkg::entry_t mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  ptt_pkg::entry_t  rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_data;
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_slot] <= 1'b1;
    end
  end

  // Forward a write that lands on the entry being read in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_slot == rd_slot)) begin
        rd_entry_r <= wr_data;
      end else if (valid_r[rd_slot]) begin
        rd_entry_r <= mem[rd_slot];
      end else begin
        rd_entry_r <= '0;
      end
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

`default_nettype wire

>>> hw/rtl/page_table_translate_unit.sv
`default_nettype none

// Page table translation unit: one request (translate, table write or table
// read) is taken per cycle. The entry store is read at the transfer edge,
// together with the input register; the entry is then checked and written
// back as the request moves from the input register into the result
// register. The store has one read and one write port; a request that
// touches the entry written by the request just ahead of it sees the new
// value through a bypass. The store reads as all zero after reset, with no
// clearing pass. When the result is not taken, input transfers stop once
// the two stages are full.
module page_table_translate_unit #(
  parameter int PROCESS_COUNT = ptt_pkg::DEF_PROCESS_COUNT
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  [1:0]                      in_req_type,
  input  wire  [ptt_pkg::PID_W-1:0]       in_process_id,
  input  wire  [ptt_pkg::VADDR_W-1:0]     in_virtual_address,
  input  wire  [ptt_pkg::MASK_W-1:0]      in_access_mask,
  input  wire  [ptt_pkg::ENTRY_W-1:0]     in_entry_data,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [ptt_pkg::VADDR_W-1:0]     out_physical_address,
  output logic [1:0]                      out_status,
  output logic [ptt_pkg::ENTRY_W-1:0]     out_entry_value
);

  localparam int DEPTH  = PROCESS_COUNT * ptt_pkg::PAGES_PER_PROCESS;
  localparam int SLOT_W = $clog2(DEPTH);

  // Stage 1: request held while the entry is read
  logic                               s1_valid_r;
  ptt_pkg::req_type_t                 s1_type_r;
  logic                               s1_pid_ok_r;
  logic [SLOT_W-1:0]                  s1_slot_r;
  logic [ptt_pkg::OFFSET_W-1:0]       s1_offset_r;
  logic [ptt_pkg::MASK_W-1:0]         s1_mask_r;
  ptt_pkg::entry_t                    s1_data_r;

  // Result register
  logic                               out_valid_r;
  logic [ptt_pkg::VADDR_W-1:0]        out_pa_r;
  ptt_pkg::status_t                   out_status_r;
  ptt_pkg::entry_t                    out_ev_r;

  logic                               in_xfer;
  logic                               advance;
  logic                               in_pid_ok;
  logic [SLOT_W-1:0]                  in_slot;
  ptt_pkg::entry_t                    entry;

  logic [ptt_pkg::VADDR_W-1:0]        pa_nxt;
  ptt_pkg::status_t                   status_nxt;
  ptt_pkg::entry_t                    ev_nxt;
  ptt_pkg::entry_t                    new_entry;
  logic                               wb_req;
  logic                               wr_en;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  assign in_pid_ok = {1'b0, in_process_id} < (ptt_pkg::PID_W + 1)'(PROCESS_COUNT);
  assign in_slot   = SLOT_W'({in_process_id,
                              in_virtual_address[ptt_pkg::VADDR_W-1:ptt_pkg::OFFSET_W]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_type_r   <= in_req_type;
      s1_pid_ok_r <= in_pid_ok;
      s1_slot_r   <= in_slot;
      s1_offset_r <= in_virtual_address[ptt_pkg::OFFSET_W-1:0];
      s1_mask_r   <= in_access_mask;
      s1_data_r   <= in_entry_data;
    end
  end

  ptt_store #(
    .DEPTH  (DEPTH),
    .SLOT_W (SLOT_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_xfer),
    .rd_slot  (in_slot),
    .rd_entry (entry),
    .wr_en    (wr_en),
    .wr_slot  (s1_slot_r),
    .wr_data  (new_entry)
  );

  always_comb begin
    pa_nxt     = '0;
    status_nxt = ptt_pkg::ST_OK;
    ev_nxt     = '0;
    new_entry  = entry | (ptt_pkg::entry_t'(1) << ptt_pkg::ACCESSED_POS);
    wb_req     = 1'b0;
    if (s1_mask_r[ptt_pkg::WRITE_BIT]) begin
      new_entry = new_entry | (ptt_pkg::entry_t'(1) << ptt_pkg::MODIFIED_POS);
    end
    case (s1_type_r)
      ptt_pkg::REQ_TRANSLATE: begin
        if (!s1_pid_ok_r) begin
          status_nxt = ptt_pkg::ST_BAD_PROCESS;
        end else if (!entry[ptt_pkg::PRESENT_POS]) begin
          status_nxt = ptt_pkg::ST_NOT_PRESENT;
        end else if ((entry & ptt_pkg::PERM_BITS
                      & ptt_pkg::entry_t'(s1_mask_r)) == '0) begin
          status_nxt = ptt_pkg::ST_DENIED;
        end else begin
          wb_req = 1'b1;
          ev_nxt = new_entry;
          pa_nxt = ptt_pkg::VADDR_W'(new_entry & ptt_pkg::FRAME_BITS)
                 | ptt_pkg::VADDR_W'(s1_offset_r);
        end
      end
      ptt_pkg::REQ_WRITE: begin
        if (!s1_pid_ok_r) begin
          status_nxt = ptt_pkg::ST_BAD_PROCESS;
        end else begin
          wb_req    = 1'b1;
          new_entry = s1_data_r;
          ev_nxt    = s1_data_r;
        end
      end
      ptt_pkg::REQ_READ: begin
        if (!s1_pid_ok_r) begin
          status_nxt = ptt_pkg::ST_BAD_PROCESS;
        end else begin
          ev_nxt = entry;
        end
      end
      default: begin
        // unused request type: empty ok result
      end
    endcase
  end

  assign wr_en = advance && wb_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pa_r     <= pa_nxt;
      out_status_r <= status_nxt;
      out_ev_r     <= ev_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_status           = out_status_r;
  assign out_entry_value      = out_ev_r;

  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled while a stage is free");

  a_wb_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (advance && s1_pid_ok_r))
    else $error("store written without a result moving out");

  a_translate_marks_accessed: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && (s1_type_r == ptt_pkg::REQ_TRANSLATE)) |->
      (new_entry[ptt_pkg::ACCESSED_POS] && new_entry[ptt_pkg::PRESENT_POS]
       && (status_nxt == ptt_pkg::ST_OK)))
    else $error("translate write-back without accessed bit");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (status_nxt != ptt_pkg::ST_OK)) |-> (!wb_req && (pa_nxt == '0)
      && (ev_nxt == '0)))
    else $error("fault result carries data or writes the store");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
